>>> sv/dsbs_pkg.sv
package dsbs_pkg;

  localparam int KEY_W = 27;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [6:0]  MONTH_MAX = 7'd99;
  localparam logic [6:0]  DAY_MAX   = 7'd99;

  localparam logic [KEY_W-1:0] YEAR_SCALE  = 27'd10000;
  localparam logic [KEY_W-1:0] MONTH_SCALE = 27'd100;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] sorted_position;
    logic [5:0] load_order;
    logic       overflowed;
  } out_t;

endpackage

>>> sv/dsbs_key.sv
module dsbs_key (
  input  dsbs_pkg::in_t               req,
  output logic [dsbs_pkg::KEY_W-1:0] key
);

  logic [13:0] year_s;
  logic [6:0]  month_s;
  logic [6:0]  day_s;

  // saturate out-of-range digits
  assign year_s  = (req.year > dsbs_pkg::YEAR_MAX) ? dsbs_pkg::YEAR_MAX : req.year;
  assign month_s = (req.month > dsbs_pkg::MONTH_MAX) ? dsbs_pkg::MONTH_MAX : req.month;
  assign day_s   = (req.day > dsbs_pkg::DAY_MAX) ? dsbs_pkg::DAY_MAX : req.day;

  assign key = dsbs_pkg::KEY_W'(year_s) * dsbs_pkg::YEAR_SCALE
             + dsbs_pkg::KEY_W'(month_s) * dsbs_pkg::MONTH_SCALE
             + dsbs_pkg::KEY_W'(day_s);

endmodule

>>> sv/dsbs_ram.sv
module dsbs_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 33
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/date_sort_and_binary_search.sv
// load request: key register, then table write, then ready; a last load adds the sort,
//   (n-1) passes over n stored dates, one ram step a cycle
// search request: key register, then a ram read and a compare per probe, a final range check on a miss
//   (up to log2(TABLE_DEPTH)+1 probes);
//   the result strobes out_valid for one cycle as busy falls
// synchronous active-low reset empties the table and marks the set closed
module date_sort_and_binary_search #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dsbs_pkg::in_t  in_data,
  output logic           out_valid,
  output dsbs_pkg::out_t out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = dsbs_pkg::KEY_W;
  localparam int EW = KW + AW;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_KEY        = 4'd1;
  localparam logic [3:0] S_LOAD       = 4'd2;
  localparam logic [3:0] S_SORT_PASS  = 4'd3;
  localparam logic [3:0] S_SORT_CARRY = 4'd4;
  localparam logic [3:0] S_SORT_CMP   = 4'd5;
  localparam logic [3:0] S_SORT_LAST  = 4'd6;
  localparam logic [3:0] S_SRCH       = 4'd7;
  localparam logic [3:0] S_SRCH_CMP   = 4'd8;

  logic [3:0]     state_r, state_nxt;
  dsbs_pkg::in_t  in_r, in_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           closed_r, closed_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CW-1:0]  pass_r, pass_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic [EW-1:0]  carry_r, carry_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;
  logic [AW-1:0]  mid_r, mid_nxt;
  logic           out_valid_r, out_valid_nxt;
  dsbs_pkg::out_t out_r, out_nxt;

  logic [KW-1:0]  key_w;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic [AW-1:0]  raddr;
  logic [EW-1:0]  rdata;

  logic [KW-1:0]  rd_key;
  logic [AW-1:0]  rd_pos;
  logic [KW-1:0]  cmp_b;
  logic           cmp_gt;
  logic           cmp_lt;
  logic [CW-1:0]  eff_cnt;
  logic           full;
  logic [CW-1:0]  cnt_new;
  logic [CW-1:0]  cnt_m1;
  logic [CW:0]    mid_sum;
  logic [AW-1:0]  mid;

  dsbs_key u_key (
    .req (in_r),
    .key (key_w)
  );

  dsbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key = rdata[EW-1:AW];
  assign rd_pos = rdata[AW-1:0];

  // shared comparator: sort carry or search key against ram output
  assign cmp_b  = (state_r == S_SRCH_CMP) ? key_r : carry_r[EW-1:AW];
  assign cmp_gt = rd_key > cmp_b;
  assign cmp_lt = rd_key < cmp_b;

  assign eff_cnt = closed_r ? '0 : cnt_r;
  assign full    = eff_cnt == CW'(TABLE_DEPTH);
  assign cnt_new = full ? eff_cnt : CW'(eff_cnt + 1'b1);
  assign cnt_m1  = CW'(cnt_r - 1'b1);
  assign mid_sum = (CW+1)'({1'b0, lo_r} + {1'b0, hi_r} - 1'b1);
  assign mid     = mid_sum[AW:1];

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    closed_nxt    = closed_r;
    ovf_nxt       = ovf_r;
    pass_nxt      = pass_r;
    j_nxt         = j_r;
    carry_nxt     = carry_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        key_nxt = key_w;
        if (in_r.kind == dsbs_pkg::KIND_LOAD) begin
          state_nxt = S_LOAD;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          state_nxt = S_SRCH;
        end
      end
      S_LOAD: begin
        closed_nxt = 1'b0;
        cnt_nxt    = cnt_new;
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          ovf_nxt = closed_r ? 1'b0 : ovf_r;
          we      = 1'b1;
          waddr   = eff_cnt[AW-1:0];
          wdata   = {key_r, eff_cnt[AW-1:0]};
        end
        state_nxt = S_IDLE;
        if (in_r.last) begin
          closed_nxt = 1'b1;
          pass_nxt   = CW'(1);
          if (cnt_new > CW'(1)) begin
            state_nxt = S_SORT_PASS;
          end
        end
      end
      S_SORT_PASS: begin
        raddr     = cnt_m1[AW-1:0];
        j_nxt     = cnt_m1[AW-1:0];
        state_nxt = S_SORT_CARRY;
      end
      S_SORT_CARRY: begin
        carry_nxt = rdata;
        raddr     = AW'(j_r - 1'b1);
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j_r;
        if (cmp_gt) begin
          wdata = rdata;
        end else begin
          wdata     = carry_r;
          carry_nxt = rdata;
        end
        raddr = AW'(j_r - 2'd2);
        if (j_r == AW'(1)) begin
          state_nxt = S_SORT_LAST;
        end else begin
          j_nxt = AW'(j_r - 1'b1);
        end
      end
      S_SORT_LAST: begin
        we       = 1'b1;
        waddr    = '0;
        wdata    = carry_r;
        pass_nxt = CW'(pass_r + 1'b1);
        if (CW'(pass_r + 1'b1) < cnt_r) begin
          state_nxt = S_SORT_PASS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          raddr     = mid;
          mid_nxt   = mid;
          state_nxt = S_SRCH_CMP;
        end else begin
          out_valid_nxt           = 1'b1;
          out_nxt.found           = 1'b0;
          out_nxt.sorted_position = '0;
          out_nxt.load_order      = '0;
          out_nxt.overflowed      = ovf_r;
          state_nxt               = S_IDLE;
        end
      end
      S_SRCH_CMP: begin
        if (cmp_lt) begin
          lo_nxt    = CW'(CW'(mid_r) + 1'b1);
          state_nxt = S_SRCH;
        end else if (cmp_gt) begin
          hi_nxt    = CW'(mid_r);
          state_nxt = S_SRCH;
        end else begin
          out_valid_nxt           = 1'b1;
          out_nxt.found           = 1'b1;
          out_nxt.sorted_position = 6'(mid_r);
          out_nxt.load_order      = 6'(rd_pos);
          out_nxt.overflowed      = ovf_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      closed_r    <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    key_r   <= key_nxt;
    pass_r  <= pass_nxt;
    j_r     <= j_nxt;
    carry_r <= carry_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    out_r   <= out_nxt;
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH     = 64;
  localparam int ITEM_GOAL = 1900;
  localparam int CALM_TAIL = 200;
  localparam int KW        = dsbs_pkg::KEY_W;
  localparam int IN_W      = $bits(dsbs_pkg::in_t);

  typedef struct {
    dsbs_pkg::in_t  req;
    bit             chk;
    dsbs_pkg::out_t exp;
  } stim_row_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  dsbs_pkg::in_t  in_data;
  logic           out_valid;
  dsbs_pkg::out_t out_data;

  date_sort_and_binary_search #(.TABLE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [KW-1:0] date_keys_q [DEPTH];
  logic [5:0]    load_idx_q  [DEPTH];
  int            rec_count = 0;
  bit            set_done  = 1'b1;
  bit            ovf_seen  = 1'b0;

  dsbs_pkg::out_t pending_answers [$];
  stim_row_t      stim_table [$];
  dsbs_pkg::in_t  set_dates [$];
  dsbs_pkg::out_t want_answer;
  int             fail_count = 0;
  int             items_sent = 0;
  bit             calm = 1'b0;

  function automatic logic [KW-1:0] date_key(dsbs_pkg::in_t r);
    logic [KW-1:0] y, m, d;
    y = KW'((r.year > dsbs_pkg::YEAR_MAX) ? dsbs_pkg::YEAR_MAX : r.year);
    m = KW'((r.month > dsbs_pkg::MONTH_MAX) ? dsbs_pkg::MONTH_MAX : r.month);
    d = KW'((r.day > dsbs_pkg::DAY_MAX) ? dsbs_pkg::DAY_MAX : r.day);
    return y * dsbs_pkg::YEAR_SCALE + m * dsbs_pkg::MONTH_SCALE + d;
  endfunction

  task automatic model_date_request(input dsbs_pkg::in_t r, output bit has_answer,
                                    output dsbs_pkg::out_t answer);
    logic [KW-1:0] key, tk;
    logic [5:0]    to;
    int            lo, hi, mid;
    key = date_key(r);
    has_answer = 1'b0;
    answer = '0;
    if (r.kind == dsbs_pkg::KIND_LOAD) begin
      if (set_done) begin
        rec_count = 0;
        ovf_seen = 1'b0;
        set_done = 1'b0;
      end
      if (rec_count < DEPTH) begin
        date_keys_q[rec_count] = key;
        load_idx_q[rec_count] = 6'(rec_count);
        rec_count++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (r.last) begin
        // bubble from the top down, equal keys never swap
        for (int p = 1; p < rec_count; p++) begin
          for (int j = rec_count - 1; j >= 1; j--) begin
            if (date_keys_q[j-1] > date_keys_q[j]) begin
              tk = date_keys_q[j-1];
              date_keys_q[j-1] = date_keys_q[j];
              date_keys_q[j] = tk;
              to = load_idx_q[j-1];
              load_idx_q[j-1] = load_idx_q[j];
              load_idx_q[j] = to;
            end
          end
        end
        set_done = 1'b1;
      end
    end else begin
      has_answer = 1'b1;
      answer.overflowed = ovf_seen;
      lo = 0;
      hi = rec_count - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key > date_keys_q[mid]) begin
          lo = mid + 1;
        end else if (key < date_keys_q[mid]) begin
          hi = mid - 1;
        end else begin
          answer.found = 1'b1;
          answer.sorted_position = 6'(mid);
          answer.load_order = load_idx_q[mid];
          lo = hi + 1;
        end
      end
    end
  endtask

  function automatic dsbs_pkg::in_t rand_date();
    dsbs_pkg::in_t r;
    r = '0;
    case ($urandom_range(0, 9))
      0: r.year = 14'($urandom_range(10000, 16383));
      1: r.year = 14'($urandom_range(0, 9999));
      default: r.year = 14'(2000 + $urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 9))
      0: r.month = 7'($urandom_range(100, 127));
      1: r.month = 7'($urandom_range(0, 99));
      default: r.month = 7'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 9))
      0: r.day = 7'($urandom_range(100, 127));
      1: r.day = 7'($urandom_range(0, 99));
      default: r.day = 7'($urandom_range(1, 3));
    endcase
    return r;
  endfunction

  function automatic dsbs_pkg::in_t search_for();
    dsbs_pkg::in_t r;
    case ($urandom_range(0, 9))
      0: r = IN_W'($urandom);
      1, 2: r = rand_date();
      default: begin
        if (set_dates.size() == 0) r = rand_date();
        else r = set_dates[$urandom_range(0, set_dates.size() - 1)];
      end
    endcase
    r.kind = dsbs_pkg::KIND_SEARCH;
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic add_row(input logic kind, input int last, input int y, input int m,
                         input int d, input int chk, input int f, input int p,
                         input int o, input int v);
    stim_row_t row;
    row.req.kind = kind;
    row.req.last = 1'(last);
    row.req.year = 14'(y);
    row.req.month = 7'(m);
    row.req.day = 7'(d);
    row.chk = 1'(chk);
    row.exp.found = 1'(f);
    row.exp.sorted_position = 6'(p);
    row.exp.load_order = 6'(o);
    row.exp.overflowed = 1'(v);
    stim_table.push_back(row);
  endtask

  task automatic send_request(input dsbs_pkg::in_t r, input bit chk,
                              input dsbs_pkg::out_t typed);
    bit             has;
    dsbs_pkg::out_t ans;
    int             gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      in_data <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_date_request(r, has, ans);
    if (has) pending_answers.push_back(chk ? typed : ans);
    items_sent++;
  endtask

  task automatic report(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected result found=%0d pos=%0d order=%0d ovf=%0d",
                         out_data.found, out_data.sorted_position,
                         out_data.load_order, out_data.overflowed));
      end else begin
        want_answer = pending_answers.pop_front();
        if (want_answer.found !== out_data.found ||
            want_answer.sorted_position !== out_data.sorted_position ||
            want_answer.load_order !== out_data.load_order ||
            want_answer.overflowed !== out_data.overflowed) begin
          report($sformatf({"mismatch: expected found=%0d pos=%0d order=%0d ovf=%0d,",
                            " got found=%0d pos=%0d order=%0d ovf=%0d"},
                           want_answer.found, want_answer.sorted_position,
                           want_answer.load_order, want_answer.overflowed,
                           out_data.found, out_data.sorted_position,
                           out_data.load_order, out_data.overflowed));
        end
      end
    end
  end

  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    dsbs_pkg::in_t r;
    int            set_no, bigs, n_loads, w;
    bit            big;
    set_no = 0;
    bigs = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;

    // empty table after reset
    add_row(dsbs_pkg::KIND_SEARCH, 0, 2020, 1, 1, 1, 0, 0, 0, 0);
    // saturated maximum, zero date, in-range maximum
    add_row(dsbs_pkg::KIND_LOAD, 0, 16383, 127, 127, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_LOAD, 1, 9999, 99, 99, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 0, 0, 0, 1, 1, 0, 1, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 9999, 99, 99, 1, 1, 1, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 1, 16383, 127, 127, 1, 1, 1, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 2020, 5, 5, 1, 0, 0, 0, 0);
    // open set, unsorted search, then duplicate keys
    add_row(dsbs_pkg::KIND_LOAD, 0, 2000, 1, 1, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_LOAD, 0, 1999, 12, 31, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 2000, 1, 1, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 1999, 12, 31, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_LOAD, 1, 2000, 1, 1, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 2000, 1, 1, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 1999, 12, 31, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 2000, 1, 2, 0, 0, 0, 0, 0);
    // single-record set
    add_row(dsbs_pkg::KIND_LOAD, 1, 1980, 2, 2, 0, 0, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 1980, 2, 2, 1, 1, 0, 0, 0);
    add_row(dsbs_pkg::KIND_SEARCH, 0, 1980, 2, 1, 1, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) send_request(stim_table[i].req, stim_table[i].chk, stim_table[i].exp);

    while (items_sent < ITEM_GOAL) begin
      calm = (items_sent >= ITEM_GOAL - CALM_TAIL) || ($urandom_range(0, 4) == 0);
      big = (set_no < 2) || (bigs < 4 && $urandom_range(0, 60) == 0);
      if (big) begin
        n_loads = $urandom_range((set_no == 0) ? 66 : 60, 70);
        bigs++;
      end else begin
        n_loads = $urandom_range(1, 12);
      end
      set_dates.delete();
      for (int k = 0; k < n_loads; k++) begin
        r = rand_date();
        r.kind = dsbs_pkg::KIND_LOAD;
        r.last = (k == n_loads - 1) && ($urandom_range(0, 9) != 0);
        set_dates.push_back(r);
        send_request(r, 0, '0);
        if ($urandom_range(0, 7) == 0) send_request(search_for(), 0, '0);
      end
      repeat ($urandom_range(1, 6)) send_request(search_for(), 0, '0);
      set_no++;
    end
    start <= 1'b0;

    w = 0;
    while (pending_answers.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (4500) @(posedge clk);
    fail_count += pending_answers.size();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
